@@ sv/t33h_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t33h_pkg
// Shared types and constants for the times-33 key bucket hash.
// ----------------------------------------------------------------------------
package t33h_pkg;

    localparam int ACC_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int TS_W    = 25;
    localparam int IDX_W   = 24;
    localparam int SHIFT33 = 5;
    localparam int CNT_W   = $clog2(ACC_W);

    localparam logic [TS_W-1:0] TS_RESET = TS_W'(1021);
    localparam logic [TS_W-1:0] TS_MAX   = TS_W'(1) << IDX_W;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic acc_step;   // fold in accepted byte
        logic div_load;   // last byte: seed divider, clear accumulator
        logic div_step;   // one restoring-division bit
        logic out_load;   // capture remainder into output register
    } cmd_t;

endpackage

@@ sv/times33_key_bucket_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// times33_key_bucket_hash
// Times-33 key hash reduced to a bucket index modulo a programmable size.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while in_stall is low, folded as
// acc = acc*33 + signed byte into a 64-bit accumulator. The request carrying
// the last-byte flag starts a bit-serial restoring remainder over the 64
// accumulator bits: the input stalls after that byte through the remainder
// steps and the hand-over of the index to the output register, longer only
// if an earlier index is still waiting at the output. A waiting index does
// not block intake of the next key. table_size of 0 acts as 1, values above
// 2^24 act as 2^24; it is sampled when the last byte of a key is taken.
// ----------------------------------------------------------------------------
module times33_key_bucket_hash
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [t33h_pkg::BYTE_W-1:0]     key_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [t33h_pkg::IDX_W-1:0]      bucket_index,
    input  logic                            cfg_wr_en,
    input  logic [t33h_pkg::TS_W-1:0]       cfg_wr_data
);

    t33h_pkg::cmd_t cmd;

    t33h_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (last_byte),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    t33h_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .key_byte     (key_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .bucket_index (bucket_index)
    );

endmodule

@@ sv/t33h_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t33h_datapath
// Accumulator, bit-serial remainder unit, table size and output registers.
// ----------------------------------------------------------------------------
module t33h_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  t33h_pkg::cmd_t                  cmd,
    input  logic [t33h_pkg::BYTE_W-1:0]     key_byte,
    input  logic                            cfg_wr_en,
    input  logic [t33h_pkg::TS_W-1:0]       cfg_wr_data,
    output logic [t33h_pkg::IDX_W-1:0]      bucket_index
);

    logic [t33h_pkg::ACC_W-1:0]  acc_reg, acc_next, acc_sum;
    logic [t33h_pkg::ACC_W-1:0]  dvd_reg, dvd_next;
    logic [t33h_pkg::IDX_W-1:0]  rem_reg, rem_next;
    logic [t33h_pkg::TS_W-1:0]   dvs_reg, dvs_next;
    logic [t33h_pkg::TS_W-1:0]   ts_reg, ts_next;
    logic [t33h_pkg::TS_W-1:0]   ts_eff;
    logic [t33h_pkg::TS_W-1:0]   rem_shift, rem_sub;
    logic [t33h_pkg::IDX_W-1:0]  out_reg, out_next;

    assign acc_sum = (acc_reg << t33h_pkg::SHIFT33) + acc_reg
                   + {{(t33h_pkg::ACC_W-t33h_pkg::BYTE_W){key_byte[t33h_pkg::BYTE_W-1]}},
                      key_byte};

    always_comb
    begin
        if (ts_reg == '0)
        begin
            ts_eff = t33h_pkg::TS_W'(1);
        end
        else if (ts_reg > t33h_pkg::TS_MAX)
        begin
            ts_eff = t33h_pkg::TS_MAX;
        end
        else
        begin
            ts_eff = ts_reg;
        end
    end

    // remainder stays below divisor <= 2^24, so the shifted value fits 25 bits
    assign rem_shift = {rem_reg, dvd_reg[t33h_pkg::ACC_W-1]};
    assign rem_sub   = rem_shift - dvs_reg;

    always_comb
    begin
        acc_next = acc_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        out_next = out_reg;
        ts_next  = cfg_wr_en ? cfg_wr_data : ts_reg;
        if (cmd.div_load)
        begin
            acc_next = '0;
            dvd_next = acc_sum;
            rem_next = '0;
            dvs_next = ts_eff;
        end
        else if (cmd.acc_step)
        begin
            acc_next = acc_sum;
        end
        if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[t33h_pkg::ACC_W-2:0], 1'b0};
            if (rem_shift >= dvs_reg)
            begin
                rem_next = rem_sub[t33h_pkg::IDX_W-1:0];
            end
            else
            begin
                rem_next = rem_shift[t33h_pkg::IDX_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_next = rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ts_reg  <= t33h_pkg::TS_RESET;
        end
        else
        begin
            acc_reg <= acc_next;
            ts_reg  <= ts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        out_reg <= out_next;
    end

    assign bucket_index = out_reg;

endmodule

@@ sv/t33h_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t33h_ctrl
// Sequencer: byte intake, remainder bit count and output request handshake.
// ----------------------------------------------------------------------------
module t33h_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last_byte,
    input  logic            out_stall,
    output logic            in_stall,
    output logic            out_valid,
    output t33h_pkg::cmd_t  cmd
);

    t33h_pkg::state_t               state_reg, state_next;
    logic [t33h_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           in_take;
    logic                           slot_free;

    assign in_take   = in_valid && (state_reg == t33h_pkg::ST_ACCUM);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            t33h_pkg::ST_ACCUM:
            begin
                if (in_take && last_byte)
                begin
                    state_next = t33h_pkg::ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            t33h_pkg::ST_DIVIDE:
            begin
                cnt_next = cnt_reg + t33h_pkg::CNT_W'(1);
                if (cnt_reg == t33h_pkg::CNT_LAST)
                begin
                    state_next = t33h_pkg::ST_HOLD;
                end
            end
            t33h_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = t33h_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = t33h_pkg::ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            t33h_pkg::ST_ACCUM:
            begin
                in_stall     = 1'b0;
                cmd.acc_step = in_take;
                cmd.div_load = in_take && last_byte;
            end
            t33h_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            t33h_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= t33h_pkg::ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
